@@ rtl/apu_pkg.sv @@
// Shared constants for the Adam parameter update engine: register codes, reset values, stage map.
package apu_pkg;

   // configuration register codes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_DECAY  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_DECAY = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_SIZE    = 2'd2;

   localparam logic [23:0] FIRST_DECAY_RESET  = 24'd15099494;
   localparam logic [23:0] SECOND_DECAY_RESET = 24'd16760439;
   localparam logic [23:0] STEP_SIZE_RESET    = 24'd167772;

   // fixed point helpers
   localparam logic [24:0] ONE_Q24 = 25'h100_0000;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
   localparam logic [47:0] MAX48   = 48'hFFFF_FFFF_FFFF;

   // stream widths
   localparam int unsigned REQ_TDATA_WIDTH = 88;
   localparam int unsigned RSP_TDATA_WIDTH = 40;

   // step counts of the iterative units
   localparam int POW_STEPS   = 16;
   localparam int DIV_M_STEPS = 31;
   localparam int DIV_V_STEPS = 48;
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_U_STEPS = 33;
   localparam int SQRT_TOP    = 62;

   // stage map
   localparam int ST_LOAD       = 0;
   localparam int ST_PROD       = 1;
   localparam int ST_MOM        = 2;
   localparam int ST_DIVISOR    = POW_STEPS + 1;
   localparam int ST_DIV_INIT   = ST_DIVISOR + 1;
   localparam int ST_DIV_FIRST  = ST_DIV_INIT + 1;
   localparam int ST_DIV_LAST   = ST_DIV_FIRST + DIV_V_STEPS - 1;
   localparam int ST_SQRT_INIT  = ST_DIV_LAST + 1;
   localparam int ST_SQRT_FIRST = ST_SQRT_INIT + 1;
   localparam int ST_SQRT_LAST  = ST_SQRT_FIRST + SQRT_STEPS - 1;
   localparam int ST_QUOT_INIT  = ST_SQRT_LAST + 1;
   localparam int ST_QUOT_FIRST = ST_QUOT_INIT + 1;
   localparam int ST_QUOT_LAST  = ST_QUOT_FIRST + DIV_U_STEPS - 1;
   localparam int ST_OUT        = ST_QUOT_LAST + 1;
   localparam int NUM_STAGES    = ST_OUT + 1;

endpackage

@@ rtl/adam_parameter_update_top.sv @@
// Adam parameter update engine: moment stores, bias correction and weight step.
//
// Usage:
//   req_* carries one parameter per transfer: index, weight and gradient (Q8.24),
//   step count, with mode and frozen in req_tuser and the end-of-pass mark in req_tlast.
//   rsp_* returns one result per request, in order: index and updated weight,
//   with req_tlast copied to rsp_tlast.
//   csr_* writes the decay factors and step size; write only while the block is idle.
// Pipeline: each request passes through every stage to the output stage.
//   The chain is 16 power steps, a 48-step restoring divider, a 32-step square root
//   and a 33-step divider for the final quotient, one step per stage.
// Throughput: one item per cycle unless the output holds. An update of the same entry
//   right behind an update of that entry waits for the moment read-modify-write.
// Reset: decays and step size return to their defaults, the pipeline empties and the
//   per-entry valid bits clear, so every moment reads as zero until written.
// Stall: when rsp_tready is low with a result waiting, the whole pipeline holds;
//   the first stage still takes a request if it is empty.
module adam_parameter_update_top #(
   parameter int ENTRIES = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // tdata: entry_index[7:0], weight_in[39:8], gradient[71:40], step_count[87:72]
   input  logic [apu_pkg::REQ_TDATA_WIDTH-1:0]    req_tdata,
   // tuser: mode[0], frozen[1]
   input  logic [1:0]                             req_tuser,
   input  logic                                   req_tlast,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: entry_out[7:0], weight_out[39:8]
   output logic [apu_pkg::RSP_TDATA_WIDTH-1:0]    rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [apu_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [23:0]                            csr_data
);
   import apu_pkg::*;

   localparam int DEPTH = (ENTRIES < 256) ? ENTRIES : 256;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef struct packed {
      logic               mode;
      logic               frozen;
      logic               last;
      logic               bypass;
      logic               neg;
      logic [7:0]         entry;
      logic signed [31:0] w;
      logic signed [31:0] g;
      logic [15:0]        t;
      logic [47:0]        g2;
      logic signed [31:0] m;
      logic [47:0]        v;
      logic signed [56:0] pm1;
      logic signed [57:0] pm2;
      logic [47:0]        pvh1;
      logic [48:0]        pvh2;
      logic [47:0]        pvl1;
      logic [48:0]        pvl2;
      logic               one1;
      logic               one2;
      logic [31:0]        r1;
      logic [31:0]        r2;
      logic [31:0]        bs1;
      logic [31:0]        bs2;
      logic [32:0]        d1;
      logic [32:0]        d2;
      logic [31:0]        ma;
      logic               ovf1;
      logic               ovf2;
      logic               ovf3;
      logic [32:0]        rem1;
      logic [32:0]        rem2;
      logic [15:0]        vlow;
      logic [30:0]        q1;
      logic [47:0]        q2;
      logic [54:0]        prod;
      logic [63:0]        sx;
      logic [63:0]        sres;
      logic [32:0]        dd3;
      logic [32:0]        rem3;
      logic [32:0]        plow;
      logic [32:0]        q3;
      logic signed [31:0] wout;
   } pipe_type;

   // configuration registers
   logic [23:0] first_decay_ff, second_decay_ff, step_size_ff;

   // pipeline
   pipe_type               st_ff [NUM_STAGES];
   pipe_type               st_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]  valid_ff;
   logic                   pipe_en, a_free, hazard, fwd, wr_en;

   // moment stores
   logic [31:0]       first_moment_ff  [DEPTH];
   logic [47:0]       second_moment_ff [DEPTH];
   logic [DEPTH-1:0]  moment_valid_ff;
   logic [31:0]       rd_m_ff;
   logic [47:0]       rd_v_ff;
   logic              rd_ok_ff;
   logic [AW-1:0]     a_addr_ff, b_addr_ff, c_addr_ff;
   logic [AW-1:0]     req_addr;
   logic [AW-1:0]     addr_tbl [256];
   logic signed [31:0] m_op;
   logic [47:0]        v_op;

   // entry to store address (entry modulo ENTRIES)
   for (genvar e = 0; e < 256; e++) begin : g_addr
      assign addr_tbl[e] = AW'(e % ENTRIES);
   end
   assign req_addr = addr_tbl[req_tdata[7:0]];

   // config write channel
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         first_decay_ff  <= FIRST_DECAY_RESET;
         second_decay_ff <= SECOND_DECAY_RESET;
         step_size_ff    <= STEP_SIZE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_DECAY:  first_decay_ff  <= csr_data;
            CSR_SECOND_DECAY: second_decay_ff <= csr_data;
            CSR_STEP_SIZE:    step_size_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // flow control: all stages move unless a result waits; a hazard holds the load stage
   assign pipe_en = !valid_ff[ST_OUT] || rsp_tready;
   assign hazard  = valid_ff[ST_LOAD] && !st_ff[ST_LOAD].bypass && valid_ff[ST_PROD] &&
                    (st_ff[ST_PROD].mode || !st_ff[ST_PROD].frozen) &&
                    (a_addr_ff == b_addr_ff);
   assign a_free  = !valid_ff[ST_LOAD] || (pipe_en && !hazard);
   assign req_tready = a_free;

   // moment write from the update stage
   assign wr_en = pipe_en && valid_ff[ST_PROD] &&
                  (st_ff[ST_PROD].mode || !st_ff[ST_PROD].frozen);

   // operands: newest value comes from the entry written on the last transfer
   assign fwd  = valid_ff[ST_MOM] && (st_ff[ST_MOM].mode || !st_ff[ST_MOM].frozen) &&
                 (c_addr_ff == a_addr_ff);
   assign m_op = fwd ? st_ff[ST_MOM].m : (rd_ok_ff ? $signed(rd_m_ff) : 32'sd0);
   assign v_op = fwd ? st_ff[ST_MOM].v : (rd_ok_ff ? rd_v_ff : 48'd0);

   // stage logic
   always_comb begin
      logic [31:0]        ga;
      logic [63:0]        g2_full;
      logic [24:0]        omb1, omb2;
      logic [63:0]        p_r1, p_r2, p_b1, p_b2;
      logic signed [58:0] msum, mfull;
      logic signed [31:0] mnew;
      logic [49:0]        vhi, vlo, vsum;
      logic [32:0]        trial1, trial2, trial3;
      logic [63:0]        sq_bit, sq_try;
      logic [64:0]        sq_diff;
      logic [30:0]        mh;
      logic [47:0]        vh;
      logic [32:0]        uq;
      logic signed [34:0] wres;

      // input load
      ga      = req_tdata[71] ? (~req_tdata[71:40] + 32'd1) : req_tdata[71:40];
      g2_full = ga * ga;
      st_in[ST_LOAD]        = '0;
      st_in[ST_LOAD].mode   = req_tuser[0];
      st_in[ST_LOAD].frozen = req_tuser[1];
      st_in[ST_LOAD].last   = req_tlast;
      st_in[ST_LOAD].bypass = req_tuser[0] | req_tuser[1];
      st_in[ST_LOAD].entry  = req_tdata[7:0];
      st_in[ST_LOAD].w      = $signed(req_tdata[39:8]);
      st_in[ST_LOAD].g      = $signed(req_tdata[71:40]);
      st_in[ST_LOAD].t      = (req_tdata[87:72] == 16'd0) ? 16'd1 : req_tdata[87:72];
      st_in[ST_LOAD].g2     = g2_full[63:16];
      st_in[ST_LOAD].one1   = 1'b1;
      st_in[ST_LOAD].one2   = 1'b1;
      st_in[ST_LOAD].bs1    = {first_decay_ff, 8'd0};
      st_in[ST_LOAD].bs2    = {second_decay_ff, 8'd0};

      omb1 = ONE_Q24 - {1'b0, first_decay_ff};
      omb2 = ONE_Q24 - {1'b0, second_decay_ff};

      for (int k = 1; k < NUM_STAGES; k++) begin
         st_in[k] = st_ff[k-1];
         p_r1 = '0; p_r2 = '0; p_b1 = '0; p_b2 = '0;
         msum = '0; mfull = '0; mnew = '0; vhi = '0; vlo = '0; vsum = '0;
         trial1 = '0; trial2 = '0; trial3 = '0; sq_bit = '0; sq_try = '0; sq_diff = '0;
         mh = '0; vh = '0; uq = '0; wres = '0;

         // bias powers, LSB-first square and multiply
         if (k <= POW_STEPS) begin
            p_r1 = st_ff[k-1].r1 * st_ff[k-1].bs1;
            p_r2 = st_ff[k-1].r2 * st_ff[k-1].bs2;
            p_b1 = st_ff[k-1].bs1 * st_ff[k-1].bs1;
            p_b2 = st_ff[k-1].bs2 * st_ff[k-1].bs2;
            if (st_ff[k-1].t[k-1]) begin
               st_in[k].r1   = st_ff[k-1].one1 ? st_ff[k-1].bs1 : p_r1[63:32];
               st_in[k].r2   = st_ff[k-1].one2 ? st_ff[k-1].bs2 : p_r2[63:32];
               st_in[k].one1 = 1'b0;
               st_in[k].one2 = 1'b0;
            end
            st_in[k].bs1 = p_b1[63:32];
            st_in[k].bs2 = p_b2[63:32];
         end

         // moment products
         if (k == ST_PROD) begin
            st_in[k].pm1  = $signed({1'b0, first_decay_ff}) * m_op;
            st_in[k].pm2  = $signed({1'b0, omb1}) * st_ff[k-1].g;
            st_in[k].pvh1 = second_decay_ff * v_op[47:24];
            st_in[k].pvl1 = second_decay_ff * v_op[23:0];
            st_in[k].pvh2 = omb2 * st_ff[k-1].g2[47:24];
            st_in[k].pvl2 = omb2 * st_ff[k-1].g2[23:0];
         end

         // moment sums, rounding and saturation
         if (k == ST_MOM) begin
            msum  = st_ff[k-1].pm1 + st_ff[k-1].pm2;
            mfull = (msum + 59'sd8388608) >>> 24;
            if (mfull > 59'sd2147483647) mnew = 32'sh7FFF_FFFF;
            else if (mfull < -59'sd2147483648) mnew = -32'sh8000_0000;
            else mnew = mfull[31:0];
            vhi  = {2'b0, st_ff[k-1].pvh1} + {1'b0, st_ff[k-1].pvh2};
            vlo  = {2'b0, st_ff[k-1].pvl1} + {1'b0, st_ff[k-1].pvl2} + 50'd8388608;
            vsum = vhi + (vlo >> 24);
            if (st_ff[k-1].mode) begin
               st_in[k].m = '0;
               st_in[k].v = '0;
            end else begin
               st_in[k].m = mnew;
               st_in[k].v = (vsum > {2'b0, MAX48}) ? MAX48 : vsum[47:0];
            end
            st_in[k].neg = mnew[31];
         end

         // divisors 1 - b^t and magnitude of m
         if (k == ST_DIVISOR) begin
            st_in[k].d1 = ONE_Q32 - {1'b0, st_ff[k-1].r1};
            st_in[k].d2 = ONE_Q32 - {1'b0, st_ff[k-1].r2};
            st_in[k].ma = st_ff[k-1].m[31] ? (~st_ff[k-1].m + 32'd1) : st_ff[k-1].m;
         end

         // divider setup with overflow detection
         if (k == ST_DIV_INIT) begin
            st_in[k].ovf1 = {st_ff[k-1].ma, 1'b0} >= st_ff[k-1].d1;
            st_in[k].rem1 = {st_ff[k-1].ma, 1'b0};
            st_in[k].ovf2 = {1'b0, st_ff[k-1].v} >= {st_ff[k-1].d2, 16'd0};
            st_in[k].rem2 = {1'b0, st_ff[k-1].v[47:16]};
            st_in[k].vlow = st_ff[k-1].v[15:0];
            st_in[k].q1   = '0;
            st_in[k].q2   = '0;
         end

         // restoring division steps for m_hat and v_hat
         if (k >= ST_DIV_FIRST && k <= ST_DIV_LAST) begin
            trial2 = {st_ff[k-1].rem2[31:0], st_ff[k-1].vlow[15]};
            st_in[k].vlow = {st_ff[k-1].vlow[14:0], 1'b0};
            if (trial2 >= st_ff[k-1].d2) begin
               st_in[k].rem2 = trial2 - st_ff[k-1].d2;
               st_in[k].q2   = {st_ff[k-1].q2[46:0], 1'b1};
            end else begin
               st_in[k].rem2 = trial2;
               st_in[k].q2   = {st_ff[k-1].q2[46:0], 1'b0};
            end
            if (k < ST_DIV_FIRST + DIV_M_STEPS) begin
               trial1 = {st_ff[k-1].rem1[31:0], 1'b0};
               if (trial1 >= st_ff[k-1].d1) begin
                  st_in[k].rem1 = trial1 - st_ff[k-1].d1;
                  st_in[k].q1   = {st_ff[k-1].q1[29:0], 1'b1};
               end else begin
                  st_in[k].rem1 = trial1;
                  st_in[k].q1   = {st_ff[k-1].q1[29:0], 1'b0};
               end
            end
         end

         // saturate quotients, scale m_hat by step size, prepare square root
         if (k == ST_SQRT_INIT) begin
            mh = st_ff[k-1].ovf1 ? 31'h7FFF_FFFF : st_ff[k-1].q1;
            vh = st_ff[k-1].ovf2 ? MAX48 : st_ff[k-1].q2;
            st_in[k].prod = step_size_ff * mh;
            st_in[k].sx   = {vh, 16'd0};
            st_in[k].sres = '0;
         end

         // square root, one result bit per stage
         if (k >= ST_SQRT_FIRST && k <= ST_SQRT_LAST) begin
            sq_bit  = 64'd1 << (SQRT_TOP - 2 * (k - ST_SQRT_FIRST));
            sq_try  = st_ff[k-1].sres | sq_bit;
            sq_diff = {1'b0, st_ff[k-1].sx} - {1'b0, sq_try};
            if (!sq_diff[64]) begin
               st_in[k].sx   = sq_diff[63:0];
               st_in[k].sres = (st_ff[k-1].sres >> 1) | sq_bit;
            end else begin
               st_in[k].sres = st_ff[k-1].sres >> 1;
            end
         end

         // final divider setup: denominator sqrt + eps
         if (k == ST_QUOT_INIT) begin
            st_in[k].dd3  = {1'b0, st_ff[k-1].sres[31:0]} + 33'd1;
            st_in[k].ovf3 = {11'd0, st_ff[k-1].prod[54:33]} >=
                            ({1'b0, st_ff[k-1].sres[31:0]} + 33'd1);
            st_in[k].rem3 = {11'd0, st_ff[k-1].prod[54:33]};
            st_in[k].plow = st_ff[k-1].prod[32:0];
            st_in[k].q3   = '0;
         end

         // final division steps
         if (k >= ST_QUOT_FIRST && k <= ST_QUOT_LAST) begin
            trial3 = {st_ff[k-1].rem3[31:0], st_ff[k-1].plow[32]};
            st_in[k].plow = {st_ff[k-1].plow[31:0], 1'b0};
            if (trial3 >= st_ff[k-1].dd3) begin
               st_in[k].rem3 = trial3 - st_ff[k-1].dd3;
               st_in[k].q3   = {st_ff[k-1].q3[31:0], 1'b1};
            end else begin
               st_in[k].rem3 = trial3;
               st_in[k].q3   = {st_ff[k-1].q3[31:0], 1'b0};
            end
         end

         // weight step with saturation; bypassed requests keep their weight
         if (k == ST_OUT) begin
            uq = st_ff[k-1].ovf3 ? '1 : st_ff[k-1].q3;
            if (st_ff[k-1].neg)
               wres = 35'(st_ff[k-1].w) + $signed({2'b0, uq});
            else
               wres = 35'(st_ff[k-1].w) - $signed({2'b0, uq});
            if (st_ff[k-1].bypass) st_in[k].wout = st_ff[k-1].w;
            else if (wres > 35'sd2147483647) st_in[k].wout = 32'sh7FFF_FFFF;
            else if (wres < -35'sd2147483648) st_in[k].wout = -32'sh8000_0000;
            else st_in[k].wout = wres[31:0];
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (a_free) valid_ff[ST_LOAD] <= req_tvalid;
         if (pipe_en) begin
            valid_ff[ST_PROD] <= valid_ff[ST_LOAD] && !hazard;
            for (int k = ST_MOM; k < NUM_STAGES; k++) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (a_free) begin
         st_ff[ST_LOAD] <= st_in[ST_LOAD];
         a_addr_ff      <= req_addr;
      end
      if (pipe_en) begin
         for (int k = ST_PROD; k < NUM_STAGES; k++) st_ff[k] <= st_in[k];
         b_addr_ff <= a_addr_ff;
         c_addr_ff <= b_addr_ff;
      end
   end

   // moment store: read on request transfer, written from the update stage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         first_moment_ff[b_addr_ff]  <= st_in[ST_MOM].m;
         second_moment_ff[b_addr_ff] <= st_in[ST_MOM].v;
      end
      if (a_free) begin
         rd_m_ff  <= first_moment_ff[req_addr];
         rd_v_ff  <= second_moment_ff[req_addr];
         rd_ok_ff <= moment_valid_ff[req_addr];
      end
   end

   // per-entry valid bits; an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         moment_valid_ff <= '0;
      end else if (wr_en) begin
         moment_valid_ff[b_addr_ff] <= 1'b1;
      end
   end

   // result channel
   assign rsp_tvalid = valid_ff[ST_OUT];
   assign rsp_tdata  = {st_ff[ST_OUT].wout, st_ff[ST_OUT].entry};
   assign rsp_tlast  = st_ff[ST_OUT].last;

endmodule

@@ sim/adam_parameter_update_top_tb.sv @@
// Testbench for the Adam parameter update engine: predicted weights checked per transfer.
`timescale 1ns / 100ps

module adam_parameter_update_top_tb;
   import apu_pkg::*;

   localparam int LATENCY_WAIT = 200;
   localparam int STALL_LIMIT  = 20000;

   typedef struct packed {
      logic        mode;
      logic        frozen;
      logic [7:0]  entry_index;
      logic [31:0] weight_in;
      logic [31:0] gradient;
      logic [15:0] step_count;
      logic        last_in;
   } param_req_type;

   typedef struct packed {
      logic [7:0]  entry_out;
      logic [31:0] weight_out;
      logic        last_out;
   } param_rsp_type;

   logic clock;
   logic reset;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        req_tvalid;
   logic        req_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [23:0] csr_data;

   adam_parameter_update_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor state
   logic signed [31:0] first_mom [256];
   logic [47:0]        second_mom [256];
   logic [23:0]        beta1_q, beta2_q, lr_q;

   param_req_type pending_reqs[$];
   param_rsp_type expected_weights[$];
   int         fail_count;
   bit         idle_enable;
   int         gap_left, stall_left, quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // 2^32 - b^t in Q0.32
   function automatic logic [63:0] bias_div(logic [23:0] b, logic [15:0] t);
      logic [63:0] r;
      logic [63:0] base;
      r = 64'h1_0000_0000;
      base = {32'd0, b, 8'd0};
      for (int i = 0; i < 16; i++) begin
         if (t[i]) r = (r * base) >> 32;
         base = (base * base) >> 32;
      end
      return 64'h1_0000_0000 - r;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // apply one request to the predicted stores and return the expected weight
   function automatic param_rsp_type predict_weight(param_req_type r);
      param_rsp_type o;
      logic [15:0] t;
      logic [7:0] idx;
      longint signed w, g, msum, mnew, res;
      logic [63:0] ga, g2, v, hi, lo, vnew, d1, d2, ma, mh, q, vh, s, u;
      logic [63:0] b1, b2;
      idx = r.entry_index;
      w = longint'(signed'(r.weight_in));
      g = longint'(signed'(r.gradient));
      t = (r.step_count == 0) ? 16'd1 : r.step_count;
      res = w;
      b1 = {40'd0, beta1_q};
      b2 = {40'd0, beta2_q};
      if (r.mode) begin
         first_mom[idx] = '0;
         second_mom[idx] = '0;
      end else if (!r.frozen) begin
         msum = longint'(b1) * longint'(first_mom[idx]) + longint'(64'h100_0000 - b1) * g;
         mnew = longint'((msum + (64'sd1 <<< 55) + (64'sd1 <<< 23)) >>> 24) - 64'sd2147483648;
         if (mnew > 64'sd2147483647) mnew = 64'sd2147483647;
         if (mnew < -64'sd2147483648) mnew = -64'sd2147483648;
         first_mom[idx] = mnew[31:0];
         ga = (g < 0) ? -g : g;
         g2 = (ga * ga) >> 16;
         v = {16'd0, second_mom[idx]};
         hi = b2 * (v >> 24) + (64'h100_0000 - b2) * (g2 >> 24);
         lo = b2 * (v & 64'hFF_FFFF) + (64'h100_0000 - b2) * (g2 & 64'hFF_FFFF);
         vnew = hi + ((lo + (64'd1 << 23)) >> 24);
         if (vnew > 64'hFFFF_FFFF_FFFF) vnew = 64'hFFFF_FFFF_FFFF;
         second_mom[idx] = vnew[47:0];
         d1 = bias_div(beta1_q, t);
         d2 = bias_div(beta2_q, t);
         ma = (mnew < 0) ? -mnew : mnew;
         mh = (ma << 32) / d1;
         if (mh > 64'd2147483647) mh = 64'd2147483647;
         q = vnew / d2;
         if (q >= 64'd65536) begin
            vh = 64'hFFFF_FFFF_FFFF;
         end else begin
            vh = (q << 32) + (((vnew % d2) << 32) / d2);
            if (vh > 64'hFFFF_FFFF_FFFF) vh = 64'hFFFF_FFFF_FFFF;
         end
         s = int_sqrt(vh << 16);
         u = ({40'd0, lr_q} * mh) / (s + 1);
         res = (mnew < 0) ? w + longint'(u) : w - longint'(u);
         if (res > 64'sd2147483647) res = 64'sd2147483647;
         if (res < -64'sd2147483648) res = -64'sd2147483648;
      end
      o.entry_out = r.entry_index;
      o.weight_out = res[31:0];
      o.last_out = r.last_in;
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_weights.push_back(predict_weight(pending_reqs.pop_front()));
         end
         if (req_tvalid && !req_tready) begin
            // hold the current transfer
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(1, 17) - 1;
            req_tvalid <= 1'b0;
         end else if ((req_tvalid && req_tready ? pending_reqs.size() > 0 :
                       pending_reqs.size() > 0)) begin
            param_req_type nxt;
            nxt = pending_reqs[0];
            req_tdata <= {nxt.step_count, nxt.gradient, nxt.weight_in, nxt.entry_index};
            req_tuser <= {nxt.frozen, nxt.mode};
            req_tlast <= nxt.last_in;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_weights.size() == 0) begin
               $error("unexpected result entry_out=%0d", rsp_tdata[7:0]);
               fail_count++;
            end else begin
               param_rsp_type e;
               e = expected_weights.pop_front();
               if (rsp_tdata[7:0] !== e.entry_out) begin
                  $error("entry_out expected %0d actual %0d", e.entry_out, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[39:8] !== e.weight_out) begin
                  $error("weight_out expected %0h actual %0h", e.weight_out, rsp_tdata[39:8]);
                  fail_count++;
               end
               if (rsp_tlast !== e.last_out) begin
                  $error("last_out expected %0b actual %0b", e.last_out, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (pending_reqs.size() > 0 || expected_weights.size() > 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [23:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FIRST_DECAY:  beta1_q = value;
         CSR_SECOND_DECAY: beta2_q = value;
         CSR_STEP_SIZE:    lr_q = value;
         default: ;
      endcase
   endtask

   task automatic drain_results();
      while (pending_reqs.size() > 0 || expected_weights.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   function automatic param_req_type rand_req(bit well_formed);
      param_req_type r;
      r.mode = well_formed ? ($urandom_range(0, 19) == 0) : 1'($urandom_range(0, 1));
      r.frozen = well_formed ? ($urandom_range(0, 9) == 0) : 1'($urandom_range(0, 1));
      r.entry_index = well_formed ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
      r.weight_in = $urandom();
      case ($urandom_range(0, 3))
         0: r.gradient = $urandom();
         1: r.gradient = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
         2: r.gradient = $signed($urandom_range(0, 4096)) - 2048;
         default: r.gradient = {{8{r.weight_in[31]}}, r.weight_in[23:0]};
      endcase
      r.step_count = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                     16'($urandom_range(0, 40));
      r.last_in = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic push_directed(logic m, logic f, logic [7:0] e, logic [31:0] w,
                                logic [31:0] g, logic [15:0] t, logic l);
      param_req_type r;
      r = '{mode: m, frozen: f, entry_index: e, weight_in: w, gradient: g,
            step_count: t, last_in: l};
      pending_reqs.push_back(r);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_FIRST_DECAY;
      csr_data = '0;
      fail_count = 0;
      idle_enable = 1'b1;
      beta1_q = FIRST_DECAY_RESET;
      beta2_q = SECOND_DECAY_RESET;
      lr_q = STEP_SIZE_RESET;
      for (int i = 0; i < 256; i++) begin
         first_mom[i] = '0;
         second_mom[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, clear, frozen, zero step, repeated entry
      push_directed(0, 0, 8'd0,   32'h7FFF_FFFF, 32'h8000_0000, 16'd1,     1'b0);
      push_directed(0, 0, 8'd255, 32'h8000_0000, 32'h7FFF_FFFF, 16'd65535, 1'b1);
      push_directed(0, 0, 8'd0,   32'h0100_0000, 32'h0100_0000, 16'd0,     1'b0);
      push_directed(0, 0, 8'd0,   32'h0100_0000, 32'hFF00_0000, 16'd2,     1'b0);
      push_directed(0, 1, 8'd0,   32'h1234_5678, 32'h0100_0000, 16'd3,     1'b0);
      push_directed(1, 1, 8'd0,   32'h0000_0001, 32'hFFFF_FFFF, 16'd4,     1'b0);
      push_directed(0, 0, 8'd0,   32'h0000_0000, 32'h0000_0000, 16'd5,     1'b1);
      push_directed(1, 0, 8'd255, 32'hFFFF_FFFF, 32'h0000_0000, 16'd1,     1'b0);
      push_directed(0, 0, 8'd255, 32'h0, 32'h0000_0001, 16'd1, 1'b1);
      push_directed(0, 0, 8'd7,   32'h8000_0000, 32'h8000_0000, 16'd1, 1'b0);
      push_directed(0, 0, 8'd7,   32'h7FFF_FFFF, 32'h8000_0000, 16'd2, 1'b1);
      drain_results();

      // phases of register settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: ;
            1: begin
               write_csr(CSR_FIRST_DECAY, 24'd0);
               write_csr(CSR_SECOND_DECAY, 24'd0);
               write_csr(CSR_STEP_SIZE, 24'hFF_FFFF);
            end
            2: begin
               write_csr(CSR_FIRST_DECAY, 24'hFF_FFFF);
               write_csr(CSR_SECOND_DECAY, 24'hFF_FFFF);
               write_csr(CSR_STEP_SIZE, 24'd0);
            end
            5: begin
               idle_enable = 1'b0;
               write_csr(CSR_FIRST_DECAY, FIRST_DECAY_RESET);
               write_csr(CSR_SECOND_DECAY, SECOND_DECAY_RESET);
               write_csr(CSR_STEP_SIZE, STEP_SIZE_RESET);
            end
            default: begin
               write_csr(CSR_FIRST_DECAY, 24'($urandom()));
               write_csr(CSR_SECOND_DECAY, 24'($urandom()));
               write_csr(CSR_STEP_SIZE, 24'($urandom()));
            end
         endcase
         for (int n = 0; n < 200; n++)
            pending_reqs.push_back(rand_req($urandom_range(0, 4) != 0));
         drain_results();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
